// File: src/clx_pkg.sv
`timescale 1ns / 1ps

package clx_pkg;

  // Default build values for the top-level parameters
  localparam int OFFSET_BITS_DEF     = 24;
  localparam int LINE_BITS_DEF       = 16;
  localparam int MAX_FRAC_DIGITS_DEF = 7;

  // Fixed widths of the token fields
  localparam int OFF_W  = 24;
  localparam int LEN_W  = 8;
  localparam int LINE_W = 16;
  localparam int INT_W  = 32;
  localparam int FRAC_W = 24;

  // Tokens one source byte can produce, and depth of the token queue
  localparam int RUN_MAX     = 3;
  localparam int QUEUE_DEPTH = 8;

  typedef enum logic [4:0] {
    K_INT      = 5'd0,
    K_FLOAT    = 5'd1,
    K_CHAR     = 5'd2,
    K_RETURN   = 5'd3,
    K_IF       = 5'd4,
    K_ELSE     = 5'd5,
    K_FOR      = 5'd6,
    K_WHILE    = 5'd7,
    K_IDENT    = 5'd8,
    K_INTNUM   = 5'd9,
    K_FLOATNUM = 5'd10,
    K_ASSIGN   = 5'd11,
    K_LT       = 5'd12,
    K_GT       = 5'd13,
    K_PLUS     = 5'd14,
    K_MINUS    = 5'd15,
    K_STAR     = 5'd16,
    K_SLASH    = 5'd17,
    K_LPAREN   = 5'd18,
    K_RPAREN   = 5'd19,
    K_LBRACE   = 5'd20,
    K_RBRACE   = 5'd21,
    K_SEMI     = 5'd22,
    K_COMMA    = 5'd23,
    K_EOF      = 5'd24,
    K_ERROR    = 5'd25
  } tok_kind_e;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_NAME    = 3'd1,
    M_INT     = 3'd2,
    M_FRAC    = 3'd3,
    M_SLASH   = 3'd4,
    M_COMMENT = 3'd5
  } scan_mode_e;

  typedef struct packed {
    tok_kind_e           kind;
    logic [OFF_W-1:0]    start;
    logic [LEN_W-1:0]    len;
    logic [LINE_W-1:0]   line;
    logic [LINE_W-1:0]   col;
    logic [INT_W-1:0]    ival;
    logic [FRAC_W-1:0]   fval;
    logic                last;
  } tok_t;

  // All tokens caused by one source byte; a float can only sit in slot 0
  typedef struct packed {
    logic [1:0]               cnt;
    logic                     is_float;
    logic [FRAC_W-1:0]        fdig_val;
    logic [2:0]               fdig_n;
    tok_t [RUN_MAX-1:0]       tok;
  } run_t;

endpackage

// File: src/clx_if.sv
`timescale 1ns / 1ps

// Source byte channel
interface clx_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       is_final;

  modport source (output valid, output char_byte, output is_final, input ready);
  modport sink   (input valid, input char_byte, input is_final, output ready);
endinterface

// Token channel
interface clx_tok_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [23:0] start_offset;
  logic [7:0]  token_length;
  logic [15:0] line_number;
  logic [15:0] column_number;
  logic [31:0] int_value;
  logic [23:0] frac_value;
  logic        last_of_run;

  modport source (output valid, output token_kind, output start_offset, output token_length,
                  output line_number, output column_number, output int_value,
                  output frac_value, output last_of_run, input ready);
  modport sink   (input valid, input token_kind, input start_offset, input token_length,
                  input line_number, input column_number, input int_value,
                  input frac_value, input last_of_run, output ready);
endinterface

// File: src/c_subset_lexer.sv
`timescale 1ns / 1ps

// Streaming scanner for a small C subset. It takes one source byte per cycle
// on byte_i and emits tokens on tok_o, each with kind, offset, length, line,
// column and numeric value. A byte may close a pending token, open a
// single-character token and end the stream, so it yields zero to three
// tokens; these pass through an input register, the scan register, three
// stages that turn a float's decimal digits into a Q0.24 fraction, and an
// eight-entry token queue. Bytes are taken every cycle while the queue has
// room for three tokens; the single token port drains one token per cycle
// while tok_o.ready is high, so a steady stream that yields more than one
// token per byte runs at the token rate. After a NUL byte or a byte flagged
// final, bytes are accepted and ignored until reset.
module c_subset_lexer import clx_pkg::*; #(
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
  parameter int LINE_BITS       = LINE_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  clx_byte_if.sink   byte_i,
  clx_tok_if.source  tok_o
);

  logic adv;
  run_t scan_run;
  run_t frac_run;

  clx_scan #(
    .OFFSET_BITS     (OFFSET_BITS),
    .LINE_BITS       (LINE_BITS),
    .MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_i),
    .adv_i  (adv),
    .run_o  (scan_run)
  );

  clx_frac u_frac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .run_i  (scan_run),
    .run_o  (frac_run)
  );

  clx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .run_i  (frac_run),
    .adv_o  (adv),
    .tok_o  (tok_o)
  );

endmodule

// File: src/clx_scan.sv
`timescale 1ns / 1ps

module clx_scan import clx_pkg::*; #(
  parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
  parameter int LINE_BITS       = LINE_BITS_DEF,
  parameter int MAX_FRAC_DIGITS = MAX_FRAC_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  clx_byte_if.sink    byte_i,
  input  logic        adv_i,
  output run_t        run_o
);

  localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Keyword spellings, first character in the low byte
  localparam logic [47:0] KW_INT    = 48'h0000_0074_6E69;
  localparam logic [47:0] KW_CHAR   = 48'h0000_7261_6863;
  localparam logic [47:0] KW_FLOAT  = 48'h0074_616F_6C66;
  localparam logic [47:0] KW_RETURN = 48'h6E72_7574_6572;
  localparam logic [47:0] KW_IF     = 48'h0000_0000_6669;
  localparam logic [47:0] KW_ELSE   = 48'h0000_6573_6C65;
  localparam logic [47:0] KW_FOR    = 48'h0000_0072_6F66;
  localparam logic [47:0] KW_WHILE  = 48'h0065_6C69_6877;

  function automatic logic is_letter(logic [7:0] ch);
    logic [7:0] lc;
    lc = ch | 8'h20;
    return (lc >= 8'h61) && (lc <= 8'h7A);
  endfunction

  function automatic logic [LINE_BITS-1:0] sat_inc(logic [LINE_BITS-1:0] v);
    return (v != LINE_MAX) ? v + LINE_BITS'(1) : v;
  endfunction

  // Kind of a pending name that the byte ch ends
  function automatic tok_kind_e name_kind(logic [7:0] ch, logic [7:0] len, logic [47:0] nm);
    tok_kind_e k;
    k = K_IDENT;
    if (ch == CH_SPACE || ch == CH_NL) begin
      if (len == 8'd3 && nm == KW_INT) k = K_INT;
      else if (len == 8'd4 && nm == KW_CHAR) k = K_CHAR;
      else if (len == 8'd5 && nm == KW_FLOAT) k = K_FLOAT;
    end
    if (k == K_IDENT && !is_letter(ch)) begin
      if (len == 8'd6 && nm == KW_RETURN) k = K_RETURN;
      else if (len == 8'd2 && nm == KW_IF) k = K_IF;
      else if (len == 8'd4 && nm == KW_ELSE) k = K_ELSE;
      else if (len == 8'd3 && nm == KW_FOR) k = K_FOR;
      else if (len == 8'd5 && nm == KW_WHILE) k = K_WHILE;
    end
    return k;
  endfunction

  function automatic tok_kind_e sym_kind(logic [7:0] ch);
    tok_kind_e k;
    unique case (ch)
      8'h3D:   k = K_ASSIGN;
      8'h3C:   k = K_LT;
      8'h3E:   k = K_GT;
      8'h2B:   k = K_PLUS;
      8'h2D:   k = K_MINUS;
      8'h2A:   k = K_STAR;
      8'h28:   k = K_LPAREN;
      8'h29:   k = K_RPAREN;
      8'h7B:   k = K_LBRACE;
      8'h7D:   k = K_RBRACE;
      8'h3B:   k = K_SEMI;
      8'h2C:   k = K_COMMA;
      default: k = K_ERROR;
    endcase
    return k;
  endfunction

  function automatic tok_t mk_tok(tok_kind_e kind, logic [OFFSET_BITS-1:0] start,
                                  logic [7:0] len, logic [LINE_BITS-1:0] ln,
                                  logic [LINE_BITS-1:0] cl, logic [31:0] iv);
    tok_t t;
    t.kind  = kind;
    t.start = OFF_W'(start);
    t.len   = len;
    t.line  = LINE_W'(ln);
    t.col   = LINE_W'(cl);
    t.ival  = iv;
    t.fval  = '0;
    t.last  = 1'b0;
    return t;
  endfunction

  // Input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_fin_q, in_fin_d;

  // Scanner state
  scan_mode_e             mode_q, mode_d;
  logic [OFFSET_BITS-1:0] start_q, start_d;
  logic [7:0]             len_q, len_d;
  logic [47:0]            name_q, name_d;
  logic [31:0]            int_q, int_d;
  logic [23:0]            frac_q, frac_d;
  logic [2:0]             fdig_q, fdig_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [LINE_BITS-1:0]   line_q, line_d;
  logic [LINE_BITS-1:0]   col_q, col_d;
  logic [LINE_BITS-1:0]   sline_q, sline_d;
  logic [LINE_BITS-1:0]   scol_q, scol_d;
  logic                   done_q, done_d;

  run_t run_q, run_d;

  logic [7:0]           c;
  logic                 letter, name_ch, digit, blank;
  logic [3:0]           dval;
  logic [LINE_BITS-1:0] col_nx;
  logic                 step;

  assign c       = in_byte_q;
  assign letter  = is_letter(c);
  assign name_ch = letter || (c == CH_UNDER);
  assign digit   = (c >= CH_ZERO) && (c <= 8'h39);
  assign blank   = (c == CH_SPACE) || ((c >= 8'h09) && (c <= 8'h0D));
  assign dval    = 4'(c - CH_ZERO);
  assign col_nx  = sat_inc(col_q);
  assign step    = in_vld_q && adv_i && !done_q;

  assign byte_i.ready = !in_vld_q || adv_i;
  assign run_o        = run_q;

  // Load the input register on a transaction, drop it when consumed
  always_comb begin
    in_vld_d  = in_vld_q;
    in_byte_d = in_byte_q;
    in_fin_d  = in_fin_q;
    if (byte_i.valid && byte_i.ready) begin
      in_vld_d  = 1'b1;
      in_byte_d = byte_i.char_byte;
      in_fin_d  = byte_i.is_final;
    end else if (adv_i) begin
      in_vld_d = 1'b0;
    end
  end

  // Scan one byte: pending token, new token, then flush and EOF at the end
  always_comb begin
    logic        again, a_v, m_v, e_v;
    tok_t        a_tok, m_tok, e_tok;
    tok_kind_e   nk;
    logic [35:0] iv_ext;
    logic [1:0]  idx;

    mode_d  = mode_q;
    start_d = start_q;
    len_d   = len_q;
    name_d  = name_q;
    int_d   = int_q;
    frac_d  = frac_q;
    fdig_d  = fdig_q;
    pos_d   = pos_q;
    line_d  = line_q;
    col_d   = col_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    done_d  = done_q;
    run_d   = '0;
    again   = 1'b0;
    a_v     = 1'b0;
    m_v     = 1'b0;
    e_v     = 1'b0;
    a_tok   = '0;
    m_tok   = '0;
    e_tok   = '0;
    nk      = K_IDENT;
    iv_ext  = '0;
    idx     = 2'd0;

    if (step) begin
      if (c != CH_NUL) begin
        unique case (mode_q)
          M_NAME: begin
            nk = name_kind(c, len_q, name_q);
            if (nk != K_IDENT || !name_ch) begin
              a_v   = 1'b1;
              a_tok = mk_tok(nk, start_q, len_q, sline_q, scol_q, '0);
              again = 1'b1;
            end else begin
              if (len_q < 8'd6) name_d = name_q | (48'(c) << {len_q[2:0], 3'b000});
              len_d = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;
            end
          end
          M_INT: begin
            if (digit) begin
              iv_ext = 36'(int_q) * 36'd10 + 36'(dval);
              int_d  = (iv_ext[35:32] != 4'd0) ? 32'hFFFF_FFFF : iv_ext[31:0];
              len_d  = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;
            end else if (c == CH_POINT) begin
              mode_d = M_FRAC;
              len_d  = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;
            end else begin
              a_v   = 1'b1;
              a_tok = mk_tok(K_INTNUM, start_q, len_q, sline_q, scol_q, int_q);
              again = 1'b1;
            end
          end
          M_FRAC: begin
            if (digit) begin
              if (fdig_q < 3'(MAX_FRAC_DIGITS)) begin
                frac_d = frac_q * 24'd10 + 24'(dval);
                fdig_d = fdig_q + 3'd1;
              end
              len_d = (len_q != 8'hFF) ? len_q + 8'd1 : len_q;
            end else begin
              a_v            = 1'b1;
              a_tok          = mk_tok(K_FLOATNUM, start_q, len_q, sline_q, scol_q, int_q);
              again          = 1'b1;
              run_d.is_float = 1'b1;
              run_d.fdig_val = frac_q;
              run_d.fdig_n   = fdig_q;
            end
          end
          M_SLASH: begin
            if (c == CH_SLASH) begin
              mode_d = M_COMMENT;
            end else begin
              a_v   = 1'b1;
              a_tok = mk_tok(K_SLASH, start_q, len_q, sline_q, scol_q, '0);
              again = 1'b1;
            end
          end
          M_COMMENT: begin
            if (c == CH_NL) mode_d = M_IDLE;
          end
          M_IDLE: again = 1'b1;
          default: mode_d = M_IDLE;
        endcase
        if (a_v) mode_d = M_IDLE;

        // Start a new token with this byte
        if (again && !blank) begin
          start_d = pos_q;
          sline_d = line_q;
          scol_d  = col_nx;
          len_d   = 8'd1;
          if (name_ch) begin
            mode_d = M_NAME;
            name_d = 48'(c);
          end else if (digit) begin
            mode_d = M_INT;
            int_d  = 32'(dval);
            frac_d = '0;
            fdig_d = '0;
          end else if (c == CH_SLASH) begin
            mode_d = M_SLASH;
          end else begin
            m_v   = 1'b1;
            m_tok = mk_tok(sym_kind(c), pos_q, 8'd1, line_q, col_nx, '0);
          end
        end

        // Advance position, line and column
        pos_d = pos_q + OFFSET_BITS'(1);
        if (c == CH_NL) begin
          line_d = sat_inc(line_q);
          col_d  = '0;
        end else begin
          col_d = col_nx;
        end
      end

      // End of stream: flush the open token, then EOF
      if (in_fin_q || c == CH_NUL) begin
        unique case (mode_d)
          M_NAME: begin
            m_v   = 1'b1;
            m_tok = mk_tok(name_kind(CH_NUL, len_d, name_d), start_d, len_d, sline_d,
                           scol_d, '0);
          end
          M_INT: begin
            m_v   = 1'b1;
            m_tok = mk_tok(K_INTNUM, start_d, len_d, sline_d, scol_d, int_d);
          end
          M_FRAC: begin
            m_v            = 1'b1;
            m_tok          = mk_tok(K_FLOATNUM, start_d, len_d, sline_d, scol_d, int_d);
            run_d.is_float = 1'b1;
            run_d.fdig_val = frac_d;
            run_d.fdig_n   = fdig_d;
          end
          M_SLASH: begin
            m_v   = 1'b1;
            m_tok = mk_tok(K_SLASH, start_d, len_d, sline_d, scol_d, '0);
          end
          default: ;
        endcase
        mode_d = M_IDLE;
        e_v    = 1'b1;
        e_tok  = mk_tok(K_EOF, pos_d, 8'd0, line_d, sat_inc(col_d), '0);
        done_d = 1'b1;
      end

      // Pack the tokens in order
      if (a_v) begin
        run_d.tok[idx] = a_tok;
        idx            = idx + 2'd1;
      end
      if (m_v) begin
        run_d.tok[idx] = m_tok;
        idx            = idx + 2'd1;
      end
      if (e_v) begin
        run_d.tok[idx] = e_tok;
        idx            = idx + 2'd1;
      end
      run_d.cnt = idx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      in_byte_q <= '0;
      in_fin_q  <= 1'b0;
      mode_q    <= M_IDLE;
      start_q   <= '0;
      len_q     <= '0;
      name_q    <= '0;
      int_q     <= '0;
      frac_q    <= '0;
      fdig_q    <= '0;
      pos_q     <= '0;
      line_q    <= LINE_BITS'(1);
      col_q     <= '0;
      sline_q   <= LINE_BITS'(1);
      scol_q    <= '0;
      done_q    <= 1'b0;
      run_q     <= '0;
    end else begin
      in_vld_q  <= in_vld_d;
      in_byte_q <= in_byte_d;
      in_fin_q  <= in_fin_d;
      mode_q    <= mode_d;
      start_q   <= start_d;
      len_q     <= len_d;
      name_q    <= name_d;
      int_q     <= int_d;
      frac_q    <= frac_d;
      fdig_q    <= fdig_d;
      pos_q     <= pos_d;
      line_q    <= line_d;
      col_q     <= col_d;
      sline_q   <= sline_d;
      scol_q    <= scol_d;
      done_q    <= done_d;
      if (adv_i) run_q <= run_d;
    end
  end

  // A float token only ever leads its run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q.is_float && run_q.cnt != 2'd0) |-> (run_q.tok[0].kind == K_FLOATNUM))
    else $error("float flag without a leading float token");

  // Once the stream has ended, no further tokens are produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && adv_i) |=> (run_q.cnt == 2'd0))
    else $error("tokens produced after end of stream");

endmodule

// File: src/clx_frac.sv
`timescale 1ns / 1ps

module clx_frac import clx_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  run_t run_i,
  output run_t run_o
);

  localparam int M_W  = 45;
  localparam int LO_W = 23;
  localparam int HI_W = M_W - LO_W;
  localparam int R_W  = FRAC_W + 1;

  // floor(2^48 / 10^n); n = 0 means no digits and a zero fraction
  function automatic logic [M_W-1:0] recip(logic [2:0] n);
    logic [M_W-1:0] m;
    unique case (n)
      3'd1:    m = 45'd28147497671065;
      3'd2:    m = 45'd2814749767106;
      3'd3:    m = 45'd281474976710;
      3'd4:    m = 45'd28147497671;
      3'd5:    m = 45'd2814749767;
      3'd6:    m = 45'd281474976;
      3'd7:    m = 45'd28147497;
      default: m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [FRAC_W-1:0] pow10(logic [2:0] n);
    logic [FRAC_W-1:0] p;
    unique case (n)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      3'd7: p = 24'd10000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

  run_t                run1_q, run2_q, run3_q;
  logic [FRAC_W+LO_W-1:0] plo1_q;
  logic [FRAC_W+HI_W-1:0] phi1_q;
  logic [FRAC_W-1:0]   qe2_q, qe3_q;
  logic [R_W-1:0]      rp3_q;

  logic [M_W-1:0]      m1;
  logic [47:0]         sum2;
  logic [FRAC_W-1:0]   p3, p4;
  logic [R_W-1:0]      rem4;
  logic [FRAC_W-1:0]   q4;

  // Stage 1: partial products of the digits by the reciprocal
  assign m1 = recip(run_i.fdig_n);

  // Stage 2: combine partial products into the estimate
  assign sum2 = 48'({phi1_q, {LO_W{1'b0}}}) + 48'(plo1_q);

  // Stage 3: estimate times the divisor, low bits only
  assign p3 = pow10(run2_q.fdig_n);

  // Stage 4: correct the estimate by one where the remainder is too large
  assign p4   = pow10(run3_q.fdig_n);
  assign rem4 = {run3_q.fdig_val[0], {FRAC_W{1'b0}}} - rp3_q;
  assign q4   = (rem4 >= R_W'(p4)) ? qe3_q + FRAC_W'(1) : qe3_q;

  always_comb begin
    run_o = run3_q;
    if (run3_q.is_float) run_o.tok[0].fval = q4;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run1_q <= '0;
      run2_q <= '0;
      run3_q <= '0;
    end else if (adv_i) begin
      run1_q <= run_i;
      run2_q <= run1_q;
      run3_q <= run2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      plo1_q <= (FRAC_W+LO_W)'(run_i.fdig_val) * (FRAC_W+LO_W)'(m1[LO_W-1:0]);
      phi1_q <= (FRAC_W+HI_W)'(run_i.fdig_val) * (FRAC_W+HI_W)'(m1[M_W-1:LO_W]);
      qe2_q  <= sum2[47:24];
      qe3_q  <= qe2_q;
      rp3_q  <= R_W'(R_W'(qe2_q) * R_W'(p3));
    end
  end

  // The reciprocal estimate is never more than one below the quotient
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run3_q.is_float && run3_q.cnt != 2'd0) |-> (rem4 < {p4, 1'b0}))
    else $error("fraction estimate out of correction range");

endmodule

// File: src/clx_queue.sv
`timescale 1ns / 1ps

module clx_queue import clx_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  run_t       run_i,
  output logic       adv_o,
  clx_tok_if.source  tok_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = PTR_W + 1;

  tok_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_q, wr_d;
  logic [PTR_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [1:0]       wr_n;
  logic             pop;
  tok_t             head;
  tok_t             wr_tok [RUN_MAX];

  // Take a whole run only when it is sure to fit
  assign adv_o = cnt_q <= CNT_W'(QUEUE_DEPTH - RUN_MAX);
  assign wr_n  = adv_o ? run_i.cnt : 2'd0;
  assign pop   = tok_o.valid && tok_o.ready;

  assign wr_d  = wr_q + PTR_W'(wr_n);
  assign rd_d  = rd_q + PTR_W'(pop);
  assign cnt_d = cnt_q + CNT_W'(wr_n) - CNT_W'(pop);

  assign head                = mem_q[rd_q];
  assign tok_o.valid         = cnt_q != '0;
  assign tok_o.token_kind    = head.kind;
  assign tok_o.start_offset  = head.start;
  assign tok_o.token_length  = head.len;
  assign tok_o.line_number   = head.line;
  assign tok_o.column_number = head.col;
  assign tok_o.int_value     = head.ival;
  assign tok_o.frac_value    = head.fval;
  assign tok_o.last_of_run   = head.last;

  // Mark the last token of the run
  always_comb begin
    for (int i = 0; i < RUN_MAX; i++) begin
      wr_tok[i]      = run_i.tok[i];
      wr_tok[i].last = (2'(i) == wr_n - 2'd1);
    end
  end

  // Write the run's tokens
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < RUN_MAX; i++) begin
      if (2'(i) < wr_n) begin
        mem_q[PTR_W'(wr_q + PTR_W'(i))] <= wr_tok[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("token queue overflow");

  // EOF always closes the run of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_o.valid && tok_o.token_kind == K_EOF) |-> tok_o.last_of_run)
    else $error("EOF token not last of its run");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import clx_pkg::*;

  localparam int RANDOM_ITEMS  = 8;
  localparam int LIMIT_CYCLES  = 1_000_000;
  localparam int DRAIN_CYCLES  = 20;
  localparam int HOLD_CYCLES   = 80;
  localparam int FRAC_DIG_MAX  = MAX_FRAC_DIGITS_DEF;
  localparam logic [LINE_W-1:0] LINE_SAT = {LINE_W{1'b1}};

  // Character codes the scanner treats specially
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_US    = 8'h5F;

  logic clk_i;
  logic rst_ni;

  clx_byte_if byte_bus ();
  clx_tok_if  tok_bus ();

  c_subset_lexer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .byte_i (byte_bus.sink),
    .tok_o  (tok_bus.source)
  );

  // Shared run state
  tok_t  tokens_due[$];
  tok_t  run_toks[$];
  int    fail_count   = 0;
  int    bytes_sent   = 0;
  int    tokens_seen  = 0;
  int    cycle_count  = 0;
  int    hold_off_len = 0;
  bit    idle_on      = 1'b1;
  string end_style    = "none";

  string keyword_list[8] = '{"int", "char", "float", "return", "if", "else", "for", "while"};
  string symbol_set      = "=<>+-*/(){};,";
  string sep_set         = " \n(;_x{";

  // Mirror of the scanner state
  scan_mode_e        lx_mode   = M_IDLE;
  logic [OFF_W-1:0]  lx_start  = '0;
  logic [LEN_W-1:0]  lx_len    = '0;
  logic [47:0]       lx_prefix = '0;
  logic [INT_W-1:0]  lx_int    = '0;
  logic [FRAC_W-1:0] lx_frac   = '0;
  logic [2:0]        lx_fdig   = '0;
  logic [OFF_W-1:0]  lx_pos    = '0;
  logic [LINE_W-1:0] lx_line   = 1;
  logic [LINE_W-1:0] lx_colc   = '0;
  logic [LINE_W-1:0] lx_sline  = 1;
  logic [LINE_W-1:0] lx_scol   = '0;
  bit                lx_done   = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog: end the run if it never drains
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL c_subset_lexer");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Character classes and keyword lookup
  // ---------------------------------------------------------------------------
  function automatic bit is_letter(input logic [7:0] c);
    logic [7:0] l;
    l = c | 8'h20;
    return (l >= "a") && (l <= "z");
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return (c == CH_SP) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic bit name_equals(input string s);
    if (lx_len != s.len()) return 1'b0;
    for (int i = 0; i < s.len(); i++)
      if (lx_prefix[8*i +: 8] != s[i]) return 1'b0;
    return 1'b1;
  endfunction

  // Keyword kind of the pending name when byte c ends it
  function automatic tok_kind_e name_kind(input logic [7:0] c);
    if ((c == CH_SP) || (c == CH_NL)) begin
      if (name_equals("int"))   return K_INT;
      if (name_equals("char"))  return K_CHAR;
      if (name_equals("float")) return K_FLOAT;
    end
    if (!is_letter(c)) begin
      if (name_equals("return")) return K_RETURN;
      if (name_equals("if"))     return K_IF;
      if (name_equals("else"))   return K_ELSE;
      if (name_equals("for"))    return K_FOR;
      if (name_equals("while"))  return K_WHILE;
    end
    return K_IDENT;
  endfunction

  function automatic tok_kind_e symbol_kind(input logic [7:0] c);
    case (c)
      "=": return K_ASSIGN;
      "<": return K_LT;
      ">": return K_GT;
      "+": return K_PLUS;
      "-": return K_MINUS;
      "*": return K_STAR;
      "(": return K_LPAREN;
      ")": return K_RPAREN;
      "{": return K_LBRACE;
      "}": return K_RBRACE;
      ";": return K_SEMI;
      ",": return K_COMMA;
      default: return K_ERROR;
    endcase
  endfunction

  function automatic logic [63:0] pow10(input logic [2:0] n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) p = p * 10;
    return p;
  endfunction

  function automatic logic [LINE_W-1:0] next_col();
    return (lx_colc < LINE_SAT) ? lx_colc + 1'b1 : LINE_SAT;
  endfunction

  // ---------------------------------------------------------------------------
  // Token predictor
  // ---------------------------------------------------------------------------
  task automatic add_token(input tok_kind_e k, input logic [OFF_W-1:0] off,
                           input logic [LEN_W-1:0] len, input logic [LINE_W-1:0] ln,
                           input logic [LINE_W-1:0] col, input logic [INT_W-1:0] iv,
                           input logic [FRAC_W-1:0] fv);
    tok_t t;
    t.kind  = k;
    t.start = off;
    t.len   = len;
    t.line  = ln;
    t.col   = col;
    t.ival  = iv;
    t.fval  = fv;
    t.last  = 1'b0;
    run_toks.push_back(t);
  endtask

  task automatic close_pending(input tok_kind_e k, input logic [INT_W-1:0] iv,
                               input logic [FRAC_W-1:0] fv);
    add_token(k, lx_start, lx_len, lx_sline, lx_scol, iv, fv);
    lx_mode = M_IDLE;
  endtask

  task automatic close_float();
    logic [63:0] num;
    logic [63:0] q;
    num = {lx_frac, 24'h0};
    q   = num / pow10(lx_fdig);
    close_pending(K_FLOATNUM, lx_int, q[FRAC_W-1:0]);
  endtask

  task automatic bump_len();
    if (lx_len < 8'd255) lx_len++;
  endtask

  // Start a new token on byte c, or emit a symbol or error token at once; a blank starts nothing
  task automatic open_token(input logic [7:0] c, input logic [LINE_W-1:0] col);
    if (is_blank(c)) return;
    lx_start = lx_pos;
    lx_sline = lx_line;
    lx_scol  = col;
    lx_len   = 1;
    if (is_letter(c) || (c == CH_US)) begin
      lx_mode   = M_NAME;
      lx_prefix = {40'h0, c};
    end else if (is_digit(c)) begin
      lx_mode = M_INT;
      lx_int  = c - CH_ZERO;
      lx_frac = '0;
      lx_fdig = '0;
    end else if (c == CH_SLASH) begin
      lx_mode = M_SLASH;
    end else begin
      add_token(symbol_kind(c), lx_pos, 1, lx_line, col, '0, '0);
    end
  endtask

  task automatic finish_stream();
    logic [LINE_W-1:0] col;
    col = next_col();
    case (lx_mode)
      M_NAME:  close_pending(name_kind(CH_NUL), '0, '0);
      M_INT:   close_pending(K_INTNUM, lx_int, '0);
      M_FRAC:  close_float();
      M_SLASH: close_pending(K_SLASH, '0, '0);
      default: ;
    endcase
    lx_mode = M_IDLE;
    add_token(K_EOF, lx_pos, 0, lx_line, col, '0, '0);
    lx_done = 1'b1;
  endtask

  // Advance the mirror by one accepted byte and queue the tokens it causes
  task automatic lex_byte(input logic [7:0] c, input logic fin);
    logic [LINE_W-1:0] col;
    tok_kind_e         k;
    bit                restart;
    logic [63:0]       v;
    tok_t              t;
    if (lx_done) return;
    run_toks.delete();
    col     = next_col();
    restart = 1'b0;
    if (c == CH_NUL) begin
      finish_stream();
    end else begin
      case (lx_mode)
        M_NAME: begin
          k = name_kind(c);
          if (k != K_IDENT) begin
            close_pending(k, '0, '0);
            restart = 1'b1;
          end else if (is_letter(c) || (c == CH_US)) begin
            if (lx_len < 6) lx_prefix[8*lx_len +: 8] = c;
            bump_len();
          end else begin
            close_pending(K_IDENT, '0, '0);
            restart = 1'b1;
          end
        end
        M_INT: begin
          if (is_digit(c)) begin
            v = lx_int;
            v = v * 10 + (c - CH_ZERO);
            lx_int = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
            bump_len();
          end else if (c == CH_DOT) begin
            lx_mode = M_FRAC;
            bump_len();
          end else begin
            close_pending(K_INTNUM, lx_int, '0);
            restart = 1'b1;
          end
        end
        M_FRAC: begin
          if (is_digit(c)) begin
            if (lx_fdig < FRAC_DIG_MAX) begin
              lx_frac = lx_frac * 10 + (c - CH_ZERO);
              lx_fdig++;
            end
            bump_len();
          end else begin
            close_float();
            restart = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            lx_mode = M_COMMENT;
          end else begin
            close_pending(K_SLASH, '0, '0);
            restart = 1'b1;
          end
        end
        M_COMMENT: begin
          if (c == CH_NL) lx_mode = M_IDLE;
        end
        default: restart = 1'b1;
      endcase
      if (restart) open_token(c, col);
      lx_pos++;
      if (c == CH_NL) begin
        if (lx_line < LINE_SAT) lx_line++;
        lx_colc = '0;
      end else begin
        lx_colc = col;
      end
      if (fin) finish_stream();
    end
    // Mark the last token of this byte and hand the run over
    if (run_toks.size() > 0) begin
      t = run_toks.pop_back();
      t.last = 1'b1;
      run_toks.push_back(t);
    end
    while (run_toks.size() > 0) tokens_due.push_back(run_toks.pop_front());
  endtask

  // ---------------------------------------------------------------------------
  // Random helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return CH_US;
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'(CH_ZERO + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_blank();
    int r;
    r = $urandom_range(8, 13);
    return (r == 8) ? CH_SP : 8'(r);
  endfunction

  // Any byte but NUL and newline, so a comment stays open
  function automatic logic [7:0] rand_comment_char();
    int r;
    r = $urandom_range(1, 254);
    return (r >= CH_NL) ? 8'(r + 1) : 8'(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Source side
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] c, input logic fin);
    int gap;
    gap = idle_on ? pick_gap() : 0;
    if (gap > 0) begin
      byte_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    byte_bus.valid     <= 1'b1;
    byte_bus.char_byte <= c;
    byte_bus.is_final  <= fin;
    @(posedge clk_i);
    while (!byte_bus.ready) @(posedge clk_i);
    lex_byte(c, fin);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // Token side: ready pattern and checker
  // ---------------------------------------------------------------------------
  initial begin
    int n;
    tok_bus.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (hold_off_len > 0) begin
        // Hold off for the requested stretch
        n = hold_off_len;
        hold_off_len = 0;
        tok_bus.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else if (idle_on && ($urandom_range(0, 3) == 0)) begin
        n = pick_gap() + 1;
        tok_bus.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end else begin
        tok_bus.ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] exp_val,
                             input logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      fail_count++;
    end
  endtask

  // Compare each token transaction with the oldest prediction
  initial begin
    tok_t due;
    forever begin
      @(posedge clk_i);
      if (tok_bus.valid && tok_bus.ready) begin
        tokens_seen++;
        if (tokens_due.size() == 0) begin
          $error("unexpected token: kind %0d at offset %0d",
                 tok_bus.token_kind, tok_bus.start_offset);
          fail_count++;
        end else begin
          due = tokens_due.pop_front();
          check_field("token_kind", due.kind, tok_bus.token_kind);
          check_field("start_offset", due.start, tok_bus.start_offset);
          check_field("token_length", due.len, tok_bus.token_length);
          check_field("line_number", due.line, tok_bus.line_number);
          check_field("column_number", due.col, tok_bus.column_number);
          check_field("int_value", due.ival, tok_bus.int_value);
          check_field("frac_value", due.fval, tok_bus.frac_value);
          check_field("last_of_run", due.last, tok_bus.last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Keywords with each kind of follower and a trailing underscore
  task automatic test_keywords();
    send_text("int\tchar\nfloat(if{while_ ");
  endtask

  // Integer saturation, a float past the digit limit and a second point
  task automatic test_numbers();
    send_text("4294967296 3.14159265 5.5.2\n");
  endtask

  // Lone slashes, comments and every blank character
  task automatic test_comments_blanks();
    send_text("a/b//x\n/");
    send_byte(CH_TAB, 1'b0);
    send_byte(CH_VT, 1'b0);
    send_byte(CH_FF, 1'b0);
    send_byte(CH_CR, 1'b0);
    send_text(" e ");
  endtask

  // All single-character symbols and assorted error bytes
  task automatic test_symbols_errors();
    send_text("=<>+-*(){};,@");
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_SP, 1'b0);
  endtask

  // Stall the token side while the source keeps offering symbols
  task automatic test_backpressure();
    idle_on      = 1'b0;
    hold_off_len = HOLD_CYCLES;
    for (int i = 0; i < 17; i++) send_byte(symbol_set[i % symbol_set.len()], 1'b0);
    send_byte(CH_NL, 1'b0);
    idle_on = 1'b1;
  endtask

  // Mostly well-formed fragments with random content, plus noise bytes
  task automatic test_random_mix();
    int stop_at;
    int r;
    int n;
    stop_at = bytes_sent + RANDOM_ITEMS;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) idle_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      if (r < 15) begin
        send_text(keyword_list[$urandom_range(0, 7)]);
        send_byte(sep_set[$urandom_range(0, sep_set.len() - 1)], 1'b0);
      end else if (r < 35) begin
        n = $urandom_range(1, 8);
        repeat (n) send_byte(rand_name_char(), 1'b0);
      end else if (r < 50) begin
        n = $urandom_range(1, 12);
        repeat (n) send_byte(rand_digit(), 1'b0);
      end else if (r < 60) begin
        n = $urandom_range(1, 3);
        repeat (n) send_byte(rand_digit(), 1'b0);
        send_byte(CH_DOT, 1'b0);
        n = $urandom_range(0, 9);
        repeat (n) send_byte(rand_digit(), 1'b0);
      end else if (r < 75) begin
        send_byte(symbol_set[$urandom_range(0, symbol_set.len() - 1)], 1'b0);
      end else if (r < 82) begin
        send_text("//");
        n = $urandom_range(0, 6);
        repeat (n) send_byte(rand_comment_char(), 1'b0);
        send_byte(CH_NL, 1'b0);
      end else if (r < 92) begin
        send_byte(rand_blank(), 1'b0);
      end else begin
        send_byte(8'($urandom_range(1, 255)), 1'b0);
      end
    end
    idle_on = 1'b1;
  endtask

  // End the stream one of three ways, then confirm later bytes are dropped
  task automatic test_stream_end();
    case ($urandom_range(0, 2))
      0: begin
        end_style = "final-flag";
        send_text("x");
        send_byte(";", 1'b1);
      end
      1: begin
        end_style = "NUL-byte";
        send_text("2.5");
        send_byte(CH_NUL, 1'($urandom_range(0, 1)));
      end
      default: begin
        end_style = "open-comment";
        send_text("//ope");
        send_byte("n", 1'b1);
      end
    endcase
    send_text("ab;");
    send_byte(CH_NUL, 1'b0);
    send_byte("q", 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             <= 1'b0;
    byte_bus.valid     <= 1'b0;
    byte_bus.char_byte <= 8'h00;
    byte_bus.is_final  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_keywords();
    test_numbers();
    test_comments_blanks();
    test_symbols_errors();
    test_backpressure();
    test_random_mix();
    test_stream_end();
    byte_bus.valid <= 1'b0;

    // Drain outstanding tokens, then watch for strays
    while (tokens_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d source bytes and %0d tokens: keywords, names, numbers,",
             bytes_sent, tokens_seen);
    $display("comments, symbols, error bytes, saturation, a long stall and a %s ending.",
             end_style);
    if (fail_count == 0) begin
      $display("PASS c_subset_lexer");
    end else begin
      $display("FAIL c_subset_lexer");
    end
    $finish;
  end

endmodule
